@@ sv/kwm_pkg.sv @@
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types, sizes and helpers for the k-way word merge block.
// ----------------------------------------------------------------------------
package kwm_pkg;

   // sizing
   localparam int MAX_ROWS = 8;
   localparam int MAX_COLS = 8;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;

   localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;  // row number
   localparam int ROWS_W  = $clog2(MAX_ROWS + 1);                   // row count
   localparam int COLS_W  = $clog2(MAX_COLS + 1);                   // col count / head
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   // word parts, fixed by the 21-byte word
   localparam int HIGH_W   = 64;
   localparam int MIDDLE_W = 64;
   localparam int LOW_W    = 40;
   localparam int WORD_W   = HIGH_W + MIDDLE_W + LOW_W;

   // control/status register file
   localparam int CFG_W       = 4;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_IN_USE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_IN_USE = CSR_INDEX_W'(1);
   localparam logic [CFG_W-1:0]       ROWS_RESET      = CFG_W'(8);
   localparam logic [CFG_W-1:0]       COLS_RESET      = CFG_W'(8);

   // high part is most significant, so an unsigned compare of the whole
   // struct orders words like a byte-string compare
   typedef struct packed {
      logic [HIGH_W-1:0]   high;
      logic [MIDDLE_W-1:0] middle;
      logic [LOW_W-1:0]    low;
   } word_type;

   typedef struct packed {
      logic                restart;   // drop partial block
      logic [ROWS_W-1:0]   rows;      // clamped rows in use
      logic [COLS_W-1:0]   cols;      // clamped cols in use
      logic [COUNT_W-1:0]  total;     // rows * cols
   } kwm_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } kwm_state_type;

   function automatic logic [ROWS_W-1:0] clamp_rows(logic [CFG_W-1:0] v);
      if (v == '0) return ROWS_W'(1);
      else if (int'(v) > MAX_ROWS) return ROWS_W'(MAX_ROWS);
      else return ROWS_W'(v);
   endfunction

   function automatic logic [COLS_W-1:0] clamp_cols(logic [CFG_W-1:0] v);
      if (v == '0) return COLS_W'(1);
      else if (int'(v) > MAX_COLS) return COLS_W'(MAX_COLS);
      else return COLS_W'(v);
   endfunction

endpackage

@@ sv/k_way_word_merge_top.sv @@
// ----------------------------------------------------------------------------
// k_way_word_merge_top
// Loads a rows x cols block of sorted rows and streams it out fully merged.
// ----------------------------------------------------------------------------
// Words stream in on req_ in row-major order, one per cycle, until
// rows_in_use * cols_in_use words have arrived; the block then stops taking
// input and merges. For each merged word it steps through the clamped rows,
// reading each row's head from the word store through its single registered
// read port and feeding it to the one 168-bit comparator, then folds in the
// last head and hands the winner to the output register (later if rsp_tready
// holds it off). Ties go to the lower row. The final merged word carries
// rsp_tlast, after which loading resumes. A write to either register drops
// any partial block. Zero register values act as 1, values above 8 as 8.
// Both registers reset to 8. Write registers only while the block is
// loading with no result pending.
// ----------------------------------------------------------------------------
module k_way_word_merge_top import kwm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // input words
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [WORD_W-1:0]       req_tdata,   // word_high, word_middle, word_low
   // merged words
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [WORD_W-1:0]       rsp_tdata,   // out_high, out_middle, out_low
   output logic                    rsp_tlast,   // out_last
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]        csr_data
);

   logic [CFG_W-1:0]  rows_cfg_ff, rows_cfg_in;
   logic [CFG_W-1:0]  cols_cfg_ff, cols_cfg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   word_type          rsp_word_ff;
   logic              rsp_last_ff;

   kwm_ctrl_type      ctrl;
   word_type          load_word;
   logic              emit_valid;
   logic              emit_ready;
   word_type          emit_word;
   logic              emit_last;
   logic              csr_fire;

   // register port: always ready, writes are registered
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_ROWS_IN_USE: rows_cfg_in = csr_data;
            CSR_COLS_IN_USE: cols_cfg_in = csr_data;
            default: ;   // unknown index: transfer taken, nothing stored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= ROWS_RESET;
         cols_cfg_ff <= COLS_RESET;
      end else begin
         rows_cfg_ff <= rows_cfg_in;
         cols_cfg_ff <= cols_cfg_in;
      end
   end

   // clamped sizes and block total; restart only on a known register
   always_comb begin
      ctrl.restart = csr_fire
                     && (csr_index == CSR_ROWS_IN_USE || csr_index == CSR_COLS_IN_USE);
      ctrl.rows    = clamp_rows(rows_cfg_ff);
      ctrl.cols    = clamp_cols(cols_cfg_ff);
      ctrl.total   = COUNT_W'(ctrl.rows) * COUNT_W'(ctrl.cols);
   end

   // first field sits in the lowest bits
   assign load_word.high   = req_tdata[HIGH_W-1:0];
   assign load_word.middle = req_tdata[HIGH_W+MIDDLE_W-1:HIGH_W];
   assign load_word.low    = req_tdata[WORD_W-1:HIGH_W+MIDDLE_W];

   kwm_merge_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .load_valid (req_tvalid),
      .load_ready (req_tready),
      .load_word  (load_word),
      .emit_valid (emit_valid),
      .emit_ready (emit_ready),
      .emit_word  (emit_word),
      .emit_last  (emit_last)
   );

   // output register: the core may hand over a word while the previous
   // one is leaving in the same cycle
   assign emit_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_valid && emit_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid && emit_ready) begin
         rsp_word_ff <= emit_word;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_word_ff.low, rsp_word_ff.middle, rsp_word_ff.high};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ sv/kwm_merge_core.sv @@
// ----------------------------------------------------------------------------
// kwm_merge_core
// Word store, row heads and the scan sequencer with one shared comparator.
// ----------------------------------------------------------------------------
module kwm_merge_core import kwm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  kwm_ctrl_type  ctrl,
   input  logic          load_valid,
   output logic          load_ready,
   input  word_type      load_word,
   output logic          emit_valid,
   input  logic          emit_ready,
   output word_type      emit_word,
   output logic          emit_last
);

   kwm_state_type       state_ff, state_in;
   logic [ADDR_W-1:0]   load_count_ff, load_count_in;
   logic [COUNT_W-1:0]  emit_count_ff, emit_count_in;
   logic [COLS_W-1:0]   heads_ff [MAX_ROWS];
   logic [COLS_W-1:0]   heads_in [MAX_ROWS];
   logic [ROW_W-1:0]    scan_row_ff, scan_row_in;
   logic [ADDR_W-1:0]   scan_base_ff, scan_base_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [ROW_W-1:0]    rd_row_ff;
   word_type            rd_word_ff;
   logic                best_found_ff, best_found_in;
   logic [ROW_W-1:0]    best_row_ff, best_row_in;
   word_type            best_word_ff, best_word_in;

   word_type            store_mem [DEPTH];
   logic [ADDR_W-1:0]   rd_addr;
   logic [COLS_W-1:0]   scan_head;
   logic                load_fire;
   logic                load_done;
   logic                scan_end;
   logic                take_cand;

   assign load_fire = load_valid && load_ready;
   assign load_done = (COUNT_W'(load_count_ff) + COUNT_W'(1)) == ctrl.total;
   assign scan_head = heads_ff[scan_row_ff];
   assign rd_addr   = scan_base_ff + ADDR_W'(scan_head);
   assign scan_end  = (ROWS_W'(scan_row_ff) + ROWS_W'(1)) == ctrl.rows;
   // shared comparator: strictly less keeps ties on the lower row
   assign take_cand = rd_valid_ff && (!best_found_ff || (rd_word_ff < best_word_ff));

   assign emit_word = best_word_ff;
   assign emit_last = (emit_count_ff + COUNT_W'(1)) == ctrl.total;

   // word store: one write port for loading, one registered read port
   always_ff @(posedge clock) begin
      if (load_fire) begin
         store_mem[load_count_ff] <= load_word;
      end
      rd_word_ff <= store_mem[rd_addr];
      rd_row_ff  <= scan_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         emit_count_ff <= '0;
         scan_row_ff   <= '0;
         scan_base_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         best_found_ff <= 1'b0;
         for (int r = 0; r < MAX_ROWS; r++) heads_ff[r] <= '0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         emit_count_ff <= emit_count_in;
         scan_row_ff   <= scan_row_in;
         scan_base_ff  <= scan_base_in;
         rd_valid_ff   <= rd_valid_in;
         best_found_ff <= best_found_in;
         for (int r = 0; r < MAX_ROWS; r++) heads_ff[r] <= heads_in[r];
      end
   end

   always_ff @(posedge clock) begin
      best_row_ff  <= best_row_in;
      best_word_ff <= best_word_in;
   end

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      emit_count_in = emit_count_ff;
      scan_row_in   = scan_row_ff;
      scan_base_in  = scan_base_ff;
      rd_valid_in   = 1'b0;
      best_found_in = best_found_ff;
      best_row_in   = best_row_ff;
      best_word_in  = best_word_ff;
      for (int r = 0; r < MAX_ROWS; r++) heads_in[r] = heads_ff[r];
      load_ready    = 1'b0;
      emit_valid    = 1'b0;

      if (take_cand) begin
         best_found_in = 1'b1;
         best_row_in   = rd_row_ff;
         best_word_in  = rd_word_ff;
      end

      case (state_ff)
         ST_LOAD: begin
            load_ready = 1'b1;
            if (ctrl.restart) begin
               load_count_in = '0;
            end else if (load_fire) begin
               if (load_done) begin
                  load_count_in = '0;
                  emit_count_in = '0;
                  scan_row_in   = '0;
                  scan_base_in  = '0;
                  best_found_in = 1'b0;
                  for (int r = 0; r < MAX_ROWS; r++) heads_in[r] = '0;
                  state_in      = ST_SCAN;
               end else begin
                  load_count_in = load_count_ff + ADDR_W'(1);
               end
            end
         end
         ST_SCAN: begin
            // issue the head of this row; rows already drained are flagged off
            rd_valid_in = scan_head < ctrl.cols;
            if (scan_end) begin
               state_in = ST_DRAIN;
            end else begin
               scan_row_in  = scan_row_ff + ROW_W'(1);
               scan_base_in = scan_base_ff + ADDR_W'(ctrl.cols);
            end
         end
         ST_DRAIN: begin
            // last head is compared this cycle
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            emit_valid = 1'b1;
            if (emit_ready) begin
               heads_in[best_row_ff] = heads_ff[best_row_ff] + COLS_W'(1);
               emit_count_in = emit_count_ff + COUNT_W'(1);
               best_found_in = 1'b0;
               scan_row_in   = '0;
               scan_base_in  = '0;
               state_in      = emit_last ? ST_LOAD : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // every output slot finds a word
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> best_found_ff)
      else $error("kwm: emit without a candidate");

   // merge never runs past the block size
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_LOAD |-> emit_count_ff < ctrl.total)
      else $error("kwm: emit count beyond total");

   // partial block stays below the block size
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> COUNT_W'(load_count_ff) < ctrl.total)
      else $error("kwm: load count beyond total");

   // scan stays inside the rows in use
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> ROWS_W'(scan_row_ff) < ctrl.rows)
      else $error("kwm: scan row out of range");

   // a finished output that is not the last starts a fresh scan
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && emit_ready && !emit_last |=> state_ff == ST_SCAN
         && scan_row_ff == '0 && !best_found_ff)
      else $error("kwm: rescan not restarted");

endmodule
